// ===== rtl/core/tew_pkg.sv =====
// ----------------------------------------------------------------------------
// tew_pkg
// shared types and constants of the wireframe edge shading pipeline
// ----------------------------------------------------------------------------
package tew_pkg;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [15:0] EDGE_COL_RST  = 16'd410;
    localparam logic [15:0] INT_COL_RST   = 16'd2048;
    localparam logic [30:0] WIDTH_RST     = 31'd65536;
    localparam logic [16:0] STEP_RST      = 17'd32768;
    localparam logic [30:0] LO_RST        = 31'd32768;

    typedef enum logic [2:0] {
        REG_EDGE_RED,
        REG_EDGE_GREEN,
        REG_EDGE_BLUE,
        REG_INT_RED,
        REG_INT_GREEN,
        REG_INT_BLUE,
        REG_LINE_WIDTH,
        REG_STEP_FRAC
    } t_reg_idx;

    typedef enum logic [1:0] {
        CASE_FULL,
        CASE_ZERO,
        CASE_MID
    } t_wcase;

    typedef struct packed {
        logic [30:0]      width;
        logic [30:0]      lo;
        logic [2:0][15:0] edge_col;
        logic [2:0][15:0] int_col;
    } t_shade_cfg;

endpackage

// ===== rtl/core/triangle_edge_wireframe_shade_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_wireframe_shade_unit
// wireframe shading: least point-to-edge-line distance, smoothstep, blend
// ----------------------------------------------------------------------------
// channel   direction  qualifier                      payload
// command   in         start && !busy                 i_point_*, i_vert0..2_*
// result    out        o_done (one cycle)             o_out_*, o_blend_weight
// config    in         psel && penable && pwrite      paddr, pwdata / prdata
//
// one transaction per cycle; on its way to the result strobe a transaction passes
// the 32-stage distance divider, 16-stage root and 16-stage ramp divider
// busy stays low: the pipeline never stalls and the receiver cannot hold off
// reset is synchronous and clears valid bits and configuration registers
// ----------------------------------------------------------------------------
module triangle_edge_wireframe_shade_unit import tew_pkg::*; #(
    parameter int COORD_BITS     = 32,
    parameter int COLOR_CHANNELS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic [COORD_BITS-1:0] i_point_z,
    input  logic [COORD_BITS-1:0] i_vert0_x,
    input  logic [COORD_BITS-1:0] i_vert0_y,
    input  logic [COORD_BITS-1:0] i_vert0_z,
    input  logic [COORD_BITS-1:0] i_vert1_x,
    input  logic [COORD_BITS-1:0] i_vert1_y,
    input  logic [COORD_BITS-1:0] i_vert1_z,
    input  logic [COORD_BITS-1:0] i_vert2_x,
    input  logic [COORD_BITS-1:0] i_vert2_y,
    input  logic [COORD_BITS-1:0] i_vert2_z,
    output logic                  o_done,
    output logic [15:0]           o_out_red,
    output logic [15:0]           o_out_green,
    output logic [15:0]           o_out_blue,
    output logic [16:0]           o_blend_weight,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW = COORD_BITS + 1;

    logic [2:0][15:0] r_edge_col;
    logic [2:0][15:0] r_int_col;
    logic [30:0]      r_width;
    logic [16:0]      r_step;
    logic [30:0]      r_lo;

    logic [16:0]      step_sat;
    logic [47:0]      n_lo;
    t_shade_cfg       shade_cfg;

    logic [2:0][COORD_BITS-1:0] pt;
    logic [2:0][COORD_BITS-1:0] v0;
    logic [2:0][COORD_BITS-1:0] v1;
    logic [2:0][COORD_BITS-1:0] v2;
    logic [2:0][COORD_BITS-1:0] lane_a [3];
    logic [2:0][COORD_BITS-1:0] lane_b [3];

    logic             ln_v    [3];
    logic             ln_have [3];
    logic [CW-1:0]    ln_dist [3];

    logic             r_m_v;
    logic             r_m_have;
    logic [CW-1:0]    r_m_dist;
    logic             n_have;
    logic [CW-1:0]    n_best;

    logic [2:0][15:0] sh_color;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_col <= {3{EDGE_COL_RST}};
            r_int_col  <= {3{INT_COL_RST}};
            r_width    <= WIDTH_RST;
            r_step     <= STEP_RST;
            r_lo       <= LO_RST;
        end else begin
            r_lo <= n_lo[46:16];
            if (psel && penable && pwrite) begin
                unique case (t_reg_idx'(paddr[4:2]))
                    REG_EDGE_RED:   r_edge_col[0] <= pwdata[15:0];
                    REG_EDGE_GREEN: r_edge_col[1] <= pwdata[15:0];
                    REG_EDGE_BLUE:  r_edge_col[2] <= pwdata[15:0];
                    REG_INT_RED:    r_int_col[0]  <= pwdata[15:0];
                    REG_INT_GREEN:  r_int_col[1]  <= pwdata[15:0];
                    REG_INT_BLUE:   r_int_col[2]  <= pwdata[15:0];
                    REG_LINE_WIDTH: r_width       <= pwdata[30:0];
                    REG_STEP_FRAC:  r_step        <= pwdata[16:0];
                endcase
            end
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_EDGE_RED:   prdata = {16'h0000, r_edge_col[0]};
            REG_EDGE_GREEN: prdata = {16'h0000, r_edge_col[1]};
            REG_EDGE_BLUE:  prdata = {16'h0000, r_edge_col[2]};
            REG_INT_RED:    prdata = {16'h0000, r_int_col[0]};
            REG_INT_GREEN:  prdata = {16'h0000, r_int_col[1]};
            REG_INT_BLUE:   prdata = {16'h0000, r_int_col[2]};
            REG_LINE_WIDTH: prdata = {1'b0, r_width};
            REG_STEP_FRAC:  prdata = {15'h0000, r_step};
        endcase
    end

    // lower ramp bound follows the width and step registers
    always_comb begin
        step_sat = (r_step > ONE_Q16) ? ONE_Q16 : r_step;
        n_lo     = 48'(r_width) * 48'(ONE_Q16 - step_sat);
    end

    assign shade_cfg.width    = r_width;
    assign shade_cfg.lo       = r_lo;
    assign shade_cfg.edge_col = r_edge_col;
    assign shade_cfg.int_col  = r_int_col;

    assign pt = {i_point_z, i_point_y, i_point_x};
    assign v0 = {i_vert0_z, i_vert0_y, i_vert0_x};
    assign v1 = {i_vert1_z, i_vert1_y, i_vert1_x};
    assign v2 = {i_vert2_z, i_vert2_y, i_vert2_x};

    assign lane_a[0] = v0;
    assign lane_b[0] = v1;
    assign lane_a[1] = v1;
    assign lane_b[1] = v2;
    assign lane_a[2] = v2;
    assign lane_b[2] = v0;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        tew_edge #(
            .COORD_BITS (COORD_BITS)
        ) u_edge (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (start && !busy),
            .i_p     (pt),
            .i_a     (lane_a[g]),
            .i_b     (lane_b[g]),
            .o_valid (ln_v[g]),
            .o_have  (ln_have[g]),
            .o_dist  (ln_dist[g])
        );
    end

    always_comb begin
        n_have = 1'b0;
        n_best = '0;
        for (int k = 0; k < 3; k++) begin
            if (ln_have[k] && (!n_have || ln_dist[k] < n_best)) begin
                n_best = ln_dist[k];
            end
            n_have = n_have | ln_have[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= ln_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_have <= n_have;
        r_m_dist <= n_best;
    end

    tew_shade #(
        .DW             (CW),
        .COLOR_CHANNELS (COLOR_CHANNELS)
    ) u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_m_v),
        .i_have   (r_m_have),
        .i_dist   (r_m_dist),
        .i_cfg    (shade_cfg),
        .o_valid  (o_done),
        .o_color  (sh_color),
        .o_weight (o_blend_weight)
    );

    assign o_out_red   = sh_color[0];
    assign o_out_green = sh_color[1];
    assign o_out_blue  = sh_color[2];

    a_no_done_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

endmodule

// ===== rtl/core/tew_pdiv.sv =====
// ----------------------------------------------------------------------------
// tew_pdiv
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tew_pdiv import tew_pkg::*; #(
    parameter int D_W    = 32,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [D_W-1:0]    i_rem,
    input  logic [Q_W-1:0]    i_low,
    input  logic [D_W-1:0]    i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [Q_W];
    logic [D_W-1:0]    r_rem  [Q_W];
    logic [Q_W-1:0]    r_low  [Q_W];
    logic [D_W-1:0]    r_den  [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stg
        logic              s_v;
        logic [D_W-1:0]    s_rem;
        logic [Q_W-1:0]    s_low;
        logic [D_W-1:0]    s_den;
        logic [Q_W-1:0]    s_quo;
        logic [SIDE_W-1:0] s_side;
        logic [D_W:0]      cur;
        logic [D_W:0]      diff;
        logic              ge;
        logic [D_W-1:0]    n_rem;

        if (g == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_rem  = i_rem;
            assign s_low  = i_low;
            assign s_den  = i_den;
            assign s_quo  = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_v    = r_v[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_low  = r_low[g-1];
            assign s_den  = r_den[g-1];
            assign s_quo  = r_quo[g-1];
            assign s_side = r_side[g-1];
        end

        assign cur   = {s_rem, s_low[Q_W-1]};
        assign diff  = cur - {1'b0, s_den};
        assign ge    = cur >= {1'b0, s_den};
        assign n_rem = ge ? diff[D_W-1:0] : cur[D_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem;
            r_low[g]  <= {s_low[Q_W-2:0], 1'b0};
            r_den[g]  <= s_den;
            r_quo[g]  <= {s_quo[Q_W-2:0], ge};
            r_side[g] <= s_side;
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

// ===== rtl/core/tew_psqrt.sv =====
// ----------------------------------------------------------------------------
// tew_psqrt
// pipelined integer square root of a 32 bit value, one root bit per stage
// ----------------------------------------------------------------------------
module tew_psqrt import tew_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [31:0]       i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [15:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int STG = 16;

    logic              r_v    [STG];
    logic [17:0]       r_rem  [STG];
    logic [15:0]       r_root [STG];
    logic [31:0]       r_rest [STG];
    logic [SIDE_W-1:0] r_side [STG];

    for (genvar g = 0; g < STG; g++) begin : g_stg
        logic              s_v;
        logic [17:0]       s_rem;
        logic [15:0]       s_root;
        logic [31:0]       s_rest;
        logic [SIDE_W-1:0] s_side;
        logic [19:0]       cur;
        logic [19:0]       trial;
        logic [19:0]       diff;
        logic              ge;

        if (g == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rest = i_rad;
            assign s_side = i_side;
        end else begin : g_next
            assign s_v    = r_v[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_root = r_root[g-1];
            assign s_rest = r_rest[g-1];
            assign s_side = r_side[g-1];
        end

        assign cur   = {s_rem, s_rest[31:30]};
        assign trial = {2'b00, s_root, 2'b01};
        assign diff  = cur - trial;
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= ge ? diff[17:0] : cur[17:0];
            r_root[g] <= {s_root[14:0], ge};
            r_rest[g] <= {s_rest[29:0], 2'b00};
            r_side[g] <= s_side;
        end
    end

    assign o_valid = r_v[STG-1];
    assign o_root  = r_root[STG-1];
    assign o_side  = r_side[STG-1];

endmodule

// ===== rtl/core/tew_edge.sv =====
// ----------------------------------------------------------------------------
// tew_edge
// distance lane: point to the line through one triangle edge, Q16.16
// ----------------------------------------------------------------------------
module tew_edge import tew_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [2:0][COORD_BITS-1:0] i_p,
    input  logic [2:0][COORD_BITS-1:0] i_a,
    input  logic [2:0][COORD_BITS-1:0] i_b,
    output logic                       o_valid,
    output logic                       o_have,
    output logic [COORD_BITS:0]        o_dist
);

    localparam int CW = COORD_BITS + 1;
    localparam int SW = $clog2(CW - 15);

    logic [6:0] r_v;

    logic [CW-1:0]        r1_e [3];
    logic [CW-1:0]        r1_d [3];
    logic [CW-1:0]        r2_e [3];
    logic [CW-1:0]        r2_d [3];
    logic [SW-1:0]        r2_s;
    logic [15:0]          r3_e [3];
    logic [15:0]          r3_d [3];
    logic [SW-1:0]        r3_s;
    logic signed [31:0]   r4_p [6];
    logic [31:0]          r4_q [3];
    logic [SW-1:0]        r4_s;
    logic [30:0]          r5_c [3];
    logic [31:0]          r5_den;
    logic [SW-1:0]        r5_s;
    logic [61:0]          r6_sq [3];
    logic [31:0]          r6_den;
    logic [SW-1:0]        r6_s;
    logic [63:0]          r7_num;
    logic [31:0]          r7_den;
    logic [SW-1:0]        r7_s;
    logic                 r7_have;

    logic [CW-1:0]        m;
    logic [SW-1:0]        n2_s;
    logic [CW-1:0]        n3_she [3];
    logic [CW-1:0]        n3_shd [3];
    logic [32:0]          n5_c [3];
    logic [32:0]          n5_mag [3];

    logic                 dv_v;
    logic [31:0]          dv_quo;
    logic [SW:0]          dv_side;
    logic                 sq_v;
    logic [15:0]          sq_root;
    logic [SW:0]          sq_side;

    logic                 r8_v;
    logic                 r8_have;
    logic [CW-1:0]        r8_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r8_v <= 1'b0;
        end else begin
            r_v  <= {r_v[5:0], i_valid};
            r8_v <= sq_v;
        end
    end

    always_comb begin
        m    = '0;
        n2_s = '0;
        for (int k = 0; k < 3; k++) begin
            m = m | (r1_e[k] ^ {CW{r1_e[k][CW-1]}}) | (r1_d[k] ^ {CW{r1_d[k][CW-1]}});
        end
        for (int j = 15; j < CW; j++) begin
            if (m[j]) n2_s = SW'(j - 14);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n3_she[k] = $signed(r2_e[k]) >>> r2_s;
            n3_shd[k] = $signed(r2_d[k]) >>> r2_s;
        end
    end

    always_comb begin
        n5_c[0] = {r4_p[0][31], r4_p[0]} - {r4_p[1][31], r4_p[1]};
        n5_c[1] = {r4_p[2][31], r4_p[2]} - {r4_p[3][31], r4_p[3]};
        n5_c[2] = {r4_p[4][31], r4_p[4]} - {r4_p[5][31], r4_p[5]};
        for (int k = 0; k < 3; k++) begin
            n5_mag[k] = n5_c[k][32] ? (33'd0 - n5_c[k]) : n5_c[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_e[k] <= {i_b[k][COORD_BITS-1], i_b[k]} - {i_a[k][COORD_BITS-1], i_a[k]};
            r1_d[k] <= {i_p[k][COORD_BITS-1], i_p[k]} - {i_a[k][COORD_BITS-1], i_a[k]};
            r2_e[k] <= r1_e[k];
            r2_d[k] <= r1_d[k];
            r3_e[k] <= n3_she[k][15:0];
            r3_d[k] <= n3_shd[k][15:0];
            r4_q[k] <= $signed(r3_e[k]) * $signed(r3_e[k]);
            r5_c[k] <= n5_mag[k][30:0];
            r6_sq[k] <= r5_c[k] * r5_c[k];
        end
        r2_s    <= n2_s;
        r3_s    <= r2_s;
        r4_p[0] <= $signed(r3_e[1]) * $signed(r3_d[2]);
        r4_p[1] <= $signed(r3_e[2]) * $signed(r3_d[1]);
        r4_p[2] <= $signed(r3_e[2]) * $signed(r3_d[0]);
        r4_p[3] <= $signed(r3_e[0]) * $signed(r3_d[2]);
        r4_p[4] <= $signed(r3_e[0]) * $signed(r3_d[1]);
        r4_p[5] <= $signed(r3_e[1]) * $signed(r3_d[0]);
        r4_s    <= r3_s;
        r5_den  <= r4_q[0] + r4_q[1] + r4_q[2];
        r5_s    <= r4_s;
        r6_den  <= r5_den;
        r6_s    <= r5_s;
        r7_num  <= 64'(r6_sq[0]) + 64'(r6_sq[1]) + 64'(r6_sq[2]);
        r7_den  <= r6_den;
        r7_s    <= r6_s;
        r7_have <= (r6_den != 32'd0);
    end

    tew_pdiv #(
        .D_W    (32),
        .Q_W    (32),
        .SIDE_W (SW + 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[6]),
        .i_rem   (r7_num[63:32]),
        .i_low   (r7_num[31:0]),
        .i_den   (r7_den),
        .i_side  ({r7_have, r7_s}),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    tew_psqrt #(
        .SIDE_W (SW + 1)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_v),
        .i_rad   (dv_quo),
        .i_side  (dv_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_ff @(posedge i_clk) begin
        r8_have <= sq_side[SW];
        r8_dist <= CW'(sq_root) << sq_side[SW-1:0];
    end

    assign o_valid = r8_v;
    assign o_have  = r8_have;
    assign o_dist  = r8_dist;

endmodule

// ===== rtl/core/tew_shade.sv =====
// ----------------------------------------------------------------------------
// tew_shade
// smoothstep of the edge distance and per-channel colour blend
// ----------------------------------------------------------------------------
module tew_shade import tew_pkg::*; #(
    parameter int DW             = 33,
    parameter int COLOR_CHANNELS = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_have,
    input  logic [DW-1:0]    i_dist,
    input  t_shade_cfg       i_cfg,
    output logic             o_valid,
    output logic [2:0][15:0] o_color,
    output logic [16:0]      o_weight
);

    localparam int CMPW = (DW > 31) ? DW : 31;

    logic             ra_v;
    t_wcase           ra_case;
    logic [30:0]      ra_rem;
    logic [30:0]      ra_span;

    logic             dv_v;
    logic [15:0]      dv_quo;
    logic [1:0]       dv_side;

    logic             rb_v;
    t_wcase           rb_case;
    logic [31:0]      rb_tt;
    logic [17:0]      rb_k;

    logic             rc_v;
    logic [16:0]      rc_w;

    logic             rd_v;
    logic [16:0]      rd_w;
    logic [32:0]      rd_me [3];
    logic [32:0]      rd_mi [3];

    logic             re_v;
    logic [16:0]      re_w;
    logic [2:0][15:0] re_color;

    logic [CMPW-1:0]  dist_x;
    logic [CMPW-1:0]  wid_x;
    logic [CMPW-1:0]  lo_x;
    logic [CMPW-1:0]  diff_x;
    t_wcase           n_case;
    logic [49:0]      n_prod;
    logic [16:0]      n_w;
    logic [33:0]      n_sum [3];

    always_comb begin
        dist_x = CMPW'(i_dist);
        wid_x  = CMPW'(i_cfg.width);
        lo_x   = CMPW'(i_cfg.lo);
        diff_x = dist_x - lo_x;
        priority if (!i_have || dist_x >= wid_x) begin
            n_case = CASE_FULL;
        end else if (dist_x <= lo_x) begin
            n_case = CASE_ZERO;
        end else begin
            n_case = CASE_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
            rb_v <= 1'b0;
            rc_v <= 1'b0;
            rd_v <= 1'b0;
            re_v <= 1'b0;
        end else begin
            ra_v <= i_valid;
            rb_v <= dv_v;
            rc_v <= rb_v;
            rd_v <= rc_v;
            re_v <= rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        ra_case <= n_case;
        ra_rem  <= diff_x[30:0];
        ra_span <= i_cfg.width - i_cfg.lo;
    end

    tew_pdiv #(
        .D_W    (31),
        .Q_W    (16),
        .SIDE_W (2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ra_v),
        .i_rem   (ra_rem),
        .i_low   (16'h0000),
        .i_den   (ra_span),
        .i_side  (ra_case),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    always_ff @(posedge i_clk) begin
        rb_case <= t_wcase'(dv_side);
        rb_tt   <= dv_quo * dv_quo;
        rb_k    <= 18'h30000 - {1'b0, dv_quo, 1'b0};
    end

    always_comb begin
        n_prod = 50'(rb_tt) * 50'(rb_k);
        unique case (rb_case)
            CASE_FULL: n_w = ONE_Q16;
            CASE_ZERO: n_w = '0;
            CASE_MID:  n_w = {1'b0, n_prod[47:32]};
            default:   n_w = ONE_Q16;
        endcase
    end

    always_ff @(posedge i_clk) begin
        rc_w <= n_w;
        rd_w <= rc_w;
        for (int i = 0; i < 3; i++) begin
            rd_me[i] <= i_cfg.edge_col[i] * (ONE_Q16 - rc_w);
            rd_mi[i] <= i_cfg.int_col[i] * rc_w;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = 34'(rd_me[i]) + 34'(rd_mi[i]) + 34'd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        re_w <= rd_w;
        for (int i = 0; i < 3; i++) begin
            re_color[i] <= (i < COLOR_CHANNELS) ? n_sum[i][31:16] : 16'h0000;
        end
    end

    assign o_valid  = re_v;
    assign o_color  = re_color;
    assign o_weight = re_w;

    a_mid_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ra_v && ra_case == CASE_MID |-> ra_rem < ra_span)
        else $error("mid-range remainder not below span");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rc_v |-> rc_w <= ONE_Q16)
        else $error("blend weight above one");

endmodule

// ===== tb/tb_triangle_edge_wireframe_shade_unit.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_edge_wireframe_shade_unit
// self-checking bench: random and directed triangles against a local model of
// edge-line distance, smoothstep weight and colour blend, across register sets
// ----------------------------------------------------------------------------
module tb_triangle_edge_wireframe_shade_unit import tew_pkg::*; ();

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [16:0] weight;
    } t_shade;

    int unsigned mismatch_cnt;

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
        mismatch_cnt++;
    endtask

    class shade_scoreboard;
        t_shade pending[$];
        logic [15:0] edge_col[3];
        logic [15:0] int_col[3];
        logic [30:0] width;
        logic [16:0] step;

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_EDGE_RED, REG_EDGE_GREEN, REG_EDGE_BLUE: edge_col[int'(idx)] = val[15:0];
                REG_INT_RED, REG_INT_GREEN, REG_INT_BLUE: int_col[int'(idx) - 3] = val[15:0];
                REG_LINE_WIDTH: width = val[30:0];
                default: step = val[16:0];
            endcase
        endfunction

        function void reset_regs();
            foreach (edge_col[i]) begin
                edge_col[i] = EDGE_COL_RST;
                int_col[i] = INT_COL_RST;
            end
            width = WIDTH_RST;
            step = STEP_RST;
        endfunction

        function automatic longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function automatic longint unsigned root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic bit edge_dist(longint p[3], longint a[3], longint b[3],
                                         output longint unsigned edist);
            longint comp[6];
            longint e[3], d[3], cx, cy, cz, lim;
            longint unsigned num, den;
            int s;
            bit fits;
            for (int i = 0; i < 3; i++) begin
                comp[i] = b[i] - a[i];
                comp[i+3] = p[i] - a[i];
            end
            s = 0;
            forever begin
                fits = 1;
                lim = 64'sd1 << (15 + s);
                foreach (comp[i]) if (comp[i] < -lim || comp[i] > lim - 1) fits = 0;
                if (fits) break;
                s++;
            end
            for (int i = 0; i < 3; i++) begin
                e[i] = floor_shr(comp[i], s);
                d[i] = floor_shr(comp[i+3], s);
            end
            cx = e[1]*d[2] - e[2]*d[1];
            cy = e[2]*d[0] - e[0]*d[2];
            cz = e[0]*d[1] - e[1]*d[0];
            num = cx*cx + cy*cy + cz*cz;
            den = e[0]*e[0] + e[1]*e[1] + e[2]*e[2];
            edist = 0;
            if (den == 0) return 0;
            edist = root(num / den) << s;
            return 1;
        endfunction

        function void note_command(logic [31:0] c[12]);
            longint p[3], v[3][3];
            longint unsigned best, edist, stp, lo, t, w, wd;
            bit have;
            t_shade r;
            for (int i = 0; i < 3; i++) begin
                p[i] = longint'($signed(c[i]));
                for (int k = 0; k < 3; k++) v[k][i] = longint'($signed(c[3 + 3*k + i]));
            end
            have = 0;
            best = 0;
            for (int k = 0; k < 3; k++)
                if (edge_dist(p, v[k], v[(k+1)%3], edist)) begin
                    if (!have || edist < best) best = edist;
                    have = 1;
                end
            wd = width;
            stp = (step > 65536) ? 65536 : step;
            lo = (wd * (65536 - stp)) >> 16;
            if (!have || best >= wd) w = 65536;
            else if (best <= lo) w = 0;
            else begin
                t = ((best - lo) << 16) / (wd - lo);
                w = (t * t * (196608 - 2*t)) >> 32;
            end
            r.red = 16'((edge_col[0]*(65536-w) + int_col[0]*w + 32768) >> 16);
            r.green = 16'((edge_col[1]*(65536-w) + int_col[1]*w + 32768) >> 16);
            r.blue = 16'((edge_col[2]*(65536-w) + int_col[2]*w + 32768) >> 16);
            r.weight = 17'(w);
            pending = {pending, r};
        endfunction

        task check_shade(t_shade got);
            t_shade x;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", got.weight, -1);
                return;
            end
            x = pending.pop_front();
            if (got.red !== x.red) report_mismatch("red", got.red, x.red);
            if (got.green !== x.green) report_mismatch("green", got.green, x.green);
            if (got.blue !== x.blue) report_mismatch("blue", got.blue, x.blue);
            if (got.weight !== x.weight) report_mismatch("weight", got.weight, x.weight);
        endtask
    endclass

    localparam int LATENCY = 78;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk, i_rst_n, start, busy, o_done, psel, penable, pwrite, pready;
    logic [31:0] coord[12];
    logic [15:0] o_out_red, o_out_green, o_out_blue;
    logic [16:0] o_blend_weight;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    longint cycle_cnt;
    int idle_pct;
    shade_scoreboard sb;

    triangle_edge_wireframe_shade_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point_x(coord[0]), .i_point_y(coord[1]), .i_point_z(coord[2]),
        .i_vert0_x(coord[3]), .i_vert0_y(coord[4]), .i_vert0_z(coord[5]),
        .i_vert1_x(coord[6]), .i_vert1_y(coord[7]), .i_vert1_z(coord[8]),
        .i_vert2_x(coord[9]), .i_vert2_y(coord[10]), .i_vert2_z(coord[11]),
        .o_done(o_done), .o_out_red(o_out_red), .o_out_green(o_out_green),
        .o_out_blue(o_out_blue), .o_blend_weight(o_blend_weight),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_shade got;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && o_done) begin
            got.red = o_out_red;
            got.green = o_out_green;
            got.blue = o_out_blue;
            got.weight = o_blend_weight;
            sb.check_shade(got);
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_triangle_edge_wireframe_shade_unit failed");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 5'(4 * int'(idx));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // holds one transaction on the ports until accepted
    task automatic send_command(logic [31:0] c[12]);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        foreach (c[i]) coord[i] <= c[i];
        start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(c);
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
            default: return 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic random_commands(int n);
        logic [31:0] c[12];
        int mode, shape;
        for (int k = 0; k < n; k++) begin
            mode = $urandom_range(5) == 0 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
            foreach (c[i]) c[i] = pick_coord(mode);
            shape = $urandom_range(9);
            // point near an edge, one degenerate edge, or all vertices coincident; else random
            if (shape < 4) begin
                for (int i = 0; i < 3; i++)
                    c[i] = c[3+i] + ((c[6+i] - c[3+i]) >>> $urandom_range(1, 3))
                           + 32'($signed($urandom_range(0, 131072)) - 65536);
            end else if (shape == 4) begin
                for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
            end else if (shape == 5) begin
                for (int i = 0; i < 6; i++) c[6+i] = c[3 + i%3];
            end
            send_command(c);
        end
    endtask

    task automatic directed_commands();
        logic [31:0] c[12];
        logic [31:0] ext[4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
        for (int k = 0; k < 16; k++) begin
            foreach (c[i]) c[i] = ext[(k + i * (k / 4 + 1)) % 4];
            send_command(c);
        end
        foreach (c[i]) c[i] = 0;
        c[6] = 32'd65536;
        c[10] = 32'd65536;
        c[0] = 32'd8192;
        c[1] = 32'd20000;
        send_command(c);
        c[1] = 32'd40000;
        send_command(c);
        c[1] = 32'd90000;
        send_command(c);
        foreach (c[i]) c[i] = 32'd12345;
        send_command(c);
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        mismatch_cnt = 0;
        cycle_cnt = 0;
        idle_pct = 0;
        i_rst_n = 0;
        start = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        foreach (coord[i]) coord[i] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        directed_commands();
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 52;
                2: idle_pct = 22;
                default: idle_pct = 52;
            endcase
            for (int r = 0; r < 6; r++)
                write_reg(t_reg_idx'(r), ph == 1 ? 32'hffff : (ph == 2 ? 0 : $urandom));
            case (ph)
                1: begin
                    write_reg(REG_LINE_WIDTH, 32'h7fffffff);
                    write_reg(REG_STEP_FRAC, 32'h1ffff);
                end
                2: begin
                    write_reg(REG_LINE_WIDTH, 0);
                    write_reg(REG_STEP_FRAC, 0);
                end
                3: begin
                    write_reg(REG_LINE_WIDTH, 32'd131072);
                    write_reg(REG_STEP_FRAC, 32'd65536);
                end
                default: begin
                    write_reg(REG_LINE_WIDTH, $urandom_range(1, 8 * 65536));
                    write_reg(REG_STEP_FRAC, $urandom_range(0, 70000));
                end
            endcase
            random_commands(50);
            wait_drained();
            random_commands(50);
            wait_drained();
        end

        wait_drained();
        if (mismatch_cnt == 0 && sb.pending.size() == 0) begin
            $display("tb_triangle_edge_wireframe_shade_unit passed");
        end else begin
            $display("tb_triangle_edge_wireframe_shade_unit failed");
        end
        $finish;
    end
endmodule
